[design/jetp_pkg.sv]
// shared types, constants and helper functions for the julia escape-time pixel engine
package jetp_pkg;

    localparam int PIX_W          = 12;
    localparam int Q_W            = 32;
    localparam int SIZE_W         = 13;
    localparam int REM_W          = SIZE_W;
    localparam int PROD_W         = PIX_W + Q_W;
    localparam int DIV_STEPS      = PROD_W;
    localparam int FRAC_BITS      = 28;
    localparam int MAX_ITERATIONS = 64;
    localparam int CNT_W          = $clog2(MAX_ITERATIONS + 1);
    localparam int CNT_OUT_W      = 7;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [63:0] BAILOUT = 64'd4 << (2 * FRAC_BITS);

    localparam logic signed [Q_W-1:0] RST_REAL_MIN = -32'sd536870912;
    localparam logic signed [Q_W-1:0] RST_REAL_MAX = 32'sd536870912;
    localparam logic signed [Q_W-1:0] RST_IMAG_MIN = -32'sd536870912;
    localparam logic signed [Q_W-1:0] RST_IMAG_MAX = 32'sd536870912;
    localparam logic signed [Q_W-1:0] RST_CONST    = '0;
    localparam logic [SIZE_W-1:0]     RST_SIZE     = 13'd1024;

    localparam logic signed [63:0] Q_MAX = 64'sd2147483647;
    localparam logic signed [63:0] Q_MIN = -64'sd2147483648;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_REAL_MIN = 3'd0,
        CFG_REAL_MAX = 3'd1,
        CFG_IMAG_MIN = 3'd2,
        CFG_IMAG_MAX = 3'd3,
        CFG_CONST_RE = 3'd4,
        CFG_CONST_IM = 3'd5,
        CFG_WIDTH    = 3'd6,
        CFG_HEIGHT   = 3'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROD,
        ST_FEED,
        ST_DIV,
        ST_MUL,
        ST_ADD
    } t_state;

    typedef struct packed {
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] word;
    } t_div_lane;

    typedef struct packed {
        logic      valid;
        t_div_lane x;
        t_div_lane y;
    } t_div_word;

    // one restoring division step: dividend bits leave at the top, quotient bits enter below
    function automatic t_div_lane div_step(input t_div_lane l, input logic [SIZE_W-1:0] d);
        logic [REM_W:0] t;
        logic           ge;
        t_div_lane      o;
        t      = {l.rem, l.word[PROD_W-1]};
        ge     = (t >= {1'b0, d});
        o.rem  = ge ? REM_W'(t - {1'b0, d}) : t[REM_W-1:0];
        o.word = {l.word[PROD_W-2:0], ge};
        return o;
    endfunction

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if (v > Q_MAX) begin
            r = Q_MAX[Q_W-1:0];
        end else if (v < Q_MIN) begin
            r = Q_MIN[Q_W-1:0];
        end else begin
            r = v[Q_W-1:0];
        end
        return r;
    endfunction

endpackage

[design/jetp_div_cell.sv]
// one divider cell: a single quotient bit for both axes, registered toward the next cell
module jetp_div_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jetp_pkg::t_div_word         i_word,
    input  logic [jetp_pkg::SIZE_W-1:0] i_div_x,
    input  logic [jetp_pkg::SIZE_W-1:0] i_div_y,
    output jetp_pkg::t_div_word         o_word
);

    logic                r_valid;
    jetp_pkg::t_div_lane r_x;
    jetp_pkg::t_div_lane r_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_word.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= jetp_pkg::div_step(i_word.x, i_div_x);
        r_y <= jetp_pkg::div_step(i_word.y, i_div_y);
    end

    assign o_word.valid = r_valid;
    assign o_word.x     = r_x;
    assign o_word.y     = r_y;

endmodule

[design/jetp_div_chain.sv]
// row of divider cells that turns the scaled coordinate products into quotients
module jetp_div_chain (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  jetp_pkg::t_div_word         i_word,
    input  logic [jetp_pkg::SIZE_W-1:0] i_div_x,
    input  logic [jetp_pkg::SIZE_W-1:0] i_div_y,
    output jetp_pkg::t_div_word         o_word
);

    jetp_pkg::t_div_word w_link [0:jetp_pkg::DIV_STEPS];

    assign w_link[0] = i_word;

    for (genvar g = 0; g < jetp_pkg::DIV_STEPS; g++) begin : g_cell
        jetp_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_word  (w_link[g]),
            .i_div_x (i_div_x),
            .i_div_y (i_div_y),
            .o_word  (w_link[g+1])
        );
    end

    assign o_word = w_link[jetp_pkg::DIV_STEPS];

endmodule

[design/julia_escape_time_pixel.sv]
// top level: pixel mapping through the divider row, then the escape-time iteration loop
//
// channel  direction  handshake              payload
// pixel    in         start / busy           i_pixel_x, i_pixel_y
// result   out        o_valid (strobe)       o_out_x, o_out_y, o_escape_count
// config   in         i_cfg_we               i_cfg_addr, i_cfg_data
//
// one pixel at a time; busy is high from the accepting edge until the result strobe
// a pixel passes the product and feed states, the 44-cell divider row, then the iteration loop,
// each iteration a registered multiply, then add, bailout and saturate
// a new word may be accepted in the cycle that carries the result strobe
// synchronous reset restores the window registers; no clearing pass is needed
// the receiver cannot stall: o_valid is high for exactly one cycle per word
module julia_escape_time_pixel (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [jetp_pkg::PIX_W-1:0]     i_pixel_x,
    input  logic [jetp_pkg::PIX_W-1:0]     i_pixel_y,
    output logic                           o_valid,
    output logic [jetp_pkg::PIX_W-1:0]     o_out_x,
    output logic [jetp_pkg::PIX_W-1:0]     o_out_y,
    output logic [jetp_pkg::CNT_OUT_W-1:0] o_escape_count,
    input  logic                           i_cfg_we,
    input  logic [jetp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [jetp_pkg::Q_W-1:0]       i_cfg_data
);

    jetp_pkg::t_state r_state;
    jetp_pkg::t_state n_state;

    logic signed [jetp_pkg::Q_W-1:0] r_real_min;
    logic signed [jetp_pkg::Q_W-1:0] r_real_max;
    logic signed [jetp_pkg::Q_W-1:0] r_imag_min;
    logic signed [jetp_pkg::Q_W-1:0] r_imag_max;
    logic signed [jetp_pkg::Q_W-1:0] r_const_re;
    logic signed [jetp_pkg::Q_W-1:0] r_const_im;
    logic [jetp_pkg::SIZE_W-1:0]     r_width;
    logic [jetp_pkg::SIZE_W-1:0]     r_height;

    logic [jetp_pkg::PIX_W-1:0]      r_px;
    logic [jetp_pkg::PIX_W-1:0]      r_py;
    logic [jetp_pkg::Q_W-1:0]        r_abs_x;
    logic [jetp_pkg::Q_W-1:0]        r_abs_y;
    logic                            r_neg_x;
    logic                            r_neg_y;
    logic [jetp_pkg::PROD_W-1:0]     r_prod_x;
    logic [jetp_pkg::PROD_W-1:0]     r_prod_y;
    logic signed [jetp_pkg::Q_W-1:0] r_re;
    logic signed [jetp_pkg::Q_W-1:0] r_im;
    logic [jetp_pkg::CNT_W-1:0]      r_count;
    logic signed [63:0]              r_rr;
    logic signed [63:0]              r_ii;
    logic signed [63:0]              r_ri;
    logic                            r_valid;
    logic [jetp_pkg::PIX_W-1:0]      r_out_x;
    logic [jetp_pkg::PIX_W-1:0]      r_out_y;
    logic [jetp_pkg::CNT_W-1:0]      r_out_cnt;

    logic signed [jetp_pkg::Q_W:0]   w_span_x;
    logic signed [jetp_pkg::Q_W:0]   w_span_y;
    logic [jetp_pkg::SIZE_W-1:0]     w_div_x;
    logic [jetp_pkg::SIZE_W-1:0]     w_div_y;
    jetp_pkg::t_div_word             w_feed;
    jetp_pkg::t_div_word             w_chain_out;
    logic signed [63:0]              w_q_x;
    logic signed [63:0]              w_q_y;
    logic signed [63:0]              w_sum_x;
    logic signed [63:0]              w_sum_y;
    logic signed [63:0]              w_nre;
    logic signed [63:0]              w_nim;
    logic                            w_bail;
    logic                            w_stop;
    logic                            w_accept;

    assign w_accept = start && (r_state == jetp_pkg::ST_IDLE);
    assign busy     = (r_state != jetp_pkg::ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_real_min <= jetp_pkg::RST_REAL_MIN;
            r_real_max <= jetp_pkg::RST_REAL_MAX;
            r_imag_min <= jetp_pkg::RST_IMAG_MIN;
            r_imag_max <= jetp_pkg::RST_IMAG_MAX;
            r_const_re <= jetp_pkg::RST_CONST;
            r_const_im <= jetp_pkg::RST_CONST;
            r_width    <= jetp_pkg::RST_SIZE;
            r_height   <= jetp_pkg::RST_SIZE;
        end else if (i_cfg_we) begin
            unique case (jetp_pkg::t_cfg_idx'(i_cfg_addr))
                jetp_pkg::CFG_REAL_MIN: r_real_min <= i_cfg_data;
                jetp_pkg::CFG_REAL_MAX: r_real_max <= i_cfg_data;
                jetp_pkg::CFG_IMAG_MIN: r_imag_min <= i_cfg_data;
                jetp_pkg::CFG_IMAG_MAX: r_imag_max <= i_cfg_data;
                jetp_pkg::CFG_CONST_RE: r_const_re <= i_cfg_data;
                jetp_pkg::CFG_CONST_IM: r_const_im <= i_cfg_data;
                jetp_pkg::CFG_WIDTH:    r_width    <= i_cfg_data[jetp_pkg::SIZE_W-1:0];
                jetp_pkg::CFG_HEIGHT:   r_height   <= i_cfg_data[jetp_pkg::SIZE_W-1:0];
            endcase
        end
    end

    // window span magnitudes and divisors
    assign w_span_x = (jetp_pkg::Q_W+1)'(r_real_max) - (jetp_pkg::Q_W+1)'(r_real_min);
    assign w_span_y = (jetp_pkg::Q_W+1)'(r_imag_max) - (jetp_pkg::Q_W+1)'(r_imag_min);
    assign w_div_x  = (r_width == '0) ? jetp_pkg::SIZE_W'(1) : r_width;
    assign w_div_y  = (r_height == '0) ? jetp_pkg::SIZE_W'(1) : r_height;

    // divider row
    assign w_feed.valid  = (r_state == jetp_pkg::ST_FEED);
    assign w_feed.x.rem  = '0;
    assign w_feed.x.word = r_prod_x;
    assign w_feed.y.rem  = '0;
    assign w_feed.y.word = r_prod_y;

    jetp_div_chain u_div_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_word  (w_feed),
        .i_div_x (w_div_x),
        .i_div_y (w_div_y),
        .o_word  (w_chain_out)
    );

    // start point from the quotients
    assign w_q_x   = $signed(64'(w_chain_out.x.word));
    assign w_q_y   = $signed(64'(w_chain_out.y.word));
    assign w_sum_x = r_neg_x ? (64'(r_real_min) - w_q_x) : (64'(r_real_min) + w_q_x);
    assign w_sum_y = r_neg_y ? (64'(r_imag_min) - w_q_y) : (64'(r_imag_min) + w_q_y);

    // iteration step
    assign w_nre  = ((r_rr - r_ii) >>> jetp_pkg::FRAC_BITS) + 64'(r_const_re);
    assign w_nim  = (r_ri >>> (jetp_pkg::FRAC_BITS - 1)) + 64'(r_const_im);
    assign w_bail = ($unsigned(r_rr) + $unsigned(r_ii)) > jetp_pkg::BAILOUT;
    assign w_stop = (r_count == jetp_pkg::CNT_W'(jetp_pkg::MAX_ITERATIONS)) || w_bail;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jetp_pkg::ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == jetp_pkg::ST_ADD) && w_stop;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jetp_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = jetp_pkg::ST_PROD;
                end
            end
            jetp_pkg::ST_PROD: n_state = jetp_pkg::ST_FEED;
            jetp_pkg::ST_FEED: n_state = jetp_pkg::ST_DIV;
            jetp_pkg::ST_DIV: begin
                if (w_chain_out.valid) begin
                    n_state = jetp_pkg::ST_MUL;
                end
            end
            jetp_pkg::ST_MUL:  n_state = jetp_pkg::ST_ADD;
            jetp_pkg::ST_ADD: begin
                n_state = w_stop ? jetp_pkg::ST_IDLE : jetp_pkg::ST_MUL;
            end
            default: n_state = jetp_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_px    <= i_pixel_x;
            r_py    <= i_pixel_y;
            r_abs_x <= jetp_pkg::Q_W'(w_span_x[jetp_pkg::Q_W] ? -w_span_x : w_span_x);
            r_abs_y <= jetp_pkg::Q_W'(w_span_y[jetp_pkg::Q_W] ? -w_span_y : w_span_y);
            r_neg_x <= w_span_x[jetp_pkg::Q_W];
            r_neg_y <= w_span_y[jetp_pkg::Q_W];
        end
        if (r_state == jetp_pkg::ST_PROD) begin
            r_prod_x <= jetp_pkg::PROD_W'(r_px) * jetp_pkg::PROD_W'(r_abs_x);
            r_prod_y <= jetp_pkg::PROD_W'(r_py) * jetp_pkg::PROD_W'(r_abs_y);
        end
        if ((r_state == jetp_pkg::ST_DIV) && w_chain_out.valid) begin
            r_re    <= jetp_pkg::sat_q(w_sum_x);
            r_im    <= jetp_pkg::sat_q(w_sum_y);
            r_count <= '0;
        end
        if (r_state == jetp_pkg::ST_MUL) begin
            r_rr <= r_re * r_re;
            r_ii <= r_im * r_im;
            r_ri <= r_re * r_im;
        end
        if (r_state == jetp_pkg::ST_ADD) begin
            if (w_stop) begin
                r_out_x   <= r_px;
                r_out_y   <= r_py;
                r_out_cnt <= r_count;
            end else begin
                r_re    <= jetp_pkg::sat_q(w_nre);
                r_im    <= jetp_pkg::sat_q(w_nim);
                r_count <= r_count + jetp_pkg::CNT_W'(1);
            end
        end
    end

    assign o_valid        = r_valid;
    assign o_out_x        = r_out_x;
    assign o_out_y        = r_out_y;
    assign o_escape_count = jetp_pkg::CNT_OUT_W'(r_out_cnt);

    a_strobe_after_add: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_state == jetp_pkg::ST_ADD))
        else $error("result strobe without a finishing iteration");

    a_accept_sets_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == jetp_pkg::ST_MUL) |->
            (r_count <= jetp_pkg::CNT_W'(jetp_pkg::MAX_ITERATIONS)))
        else $error("iteration started past the limit");

    a_chain_only_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chain_out.valid |-> (r_state == jetp_pkg::ST_DIV))
        else $error("divider row delivered outside the wait state");

endmodule

[sim/tb_julia_escape_time_pixel.sv]
// testbench for the julia escape-time pixel engine: directed and random pixels
`timescale 1ns / 1ps

module tb_julia_escape_time_pixel;

    localparam int              FRAC      = 28;
    localparam longint unsigned ESCAPE_SQ = 64'd4 << (2 * FRAC);
    localparam longint          Q_TOP     = 64'sh7fff_ffff;
    localparam longint          Q_BOTTOM  = -64'sh8000_0000;
    localparam int              Q_ONE     = 268435456;
    localparam int              Q_HI_INT  = 32'h7fff_ffff;
    localparam int              Q_LO_INT  = 32'h8000_0000;
    localparam int              PER_PHASE = 67;

    typedef struct packed {
        logic [jetp_pkg::PIX_W-1:0]     x;
        logic [jetp_pkg::PIX_W-1:0]     y;
        logic [jetp_pkg::CNT_OUT_W-1:0] count;
    } t_pixel_word;

    logic                              i_clk;
    logic                              i_rst_n;
    logic                              start;
    logic                              busy;
    logic [jetp_pkg::PIX_W-1:0]        i_pixel_x;
    logic [jetp_pkg::PIX_W-1:0]        i_pixel_y;
    logic                              o_valid;
    logic [jetp_pkg::PIX_W-1:0]        o_out_x;
    logic [jetp_pkg::PIX_W-1:0]        o_out_y;
    logic [jetp_pkg::CNT_OUT_W-1:0]    o_escape_count;
    logic                              i_cfg_we;
    logic [jetp_pkg::CFG_ADDR_W-1:0]   i_cfg_addr;
    logic [jetp_pkg::Q_W-1:0]          i_cfg_data;

    // local copy of the window registers
    int                          win_re_lo = -536870912;
    int                          win_re_hi = 536870912;
    int                          win_im_lo = -536870912;
    int                          win_im_hi = 536870912;
    int                          c_re      = 0;
    int                          c_im      = 0;
    logic [jetp_pkg::SIZE_W-1:0] img_w     = 13'd1024;
    logic [jetp_pkg::SIZE_W-1:0] img_h     = 13'd1024;

    t_pixel_word pending_pixels[$];
    int          idle_pct         = 12;
    int          idle_pct_modes[3] = '{12, 68, 0};
    int          mismatches       = 0;
    int          words_sent       = 0;
    int          words_checked    = 0;
    int          settings_applied = 0;
    int          limit_hits       = 0;

    julia_escape_time_pixel i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .o_valid        (o_valid),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y),
        .o_escape_count (o_escape_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic int clamp_q(input longint v);
        if (v > Q_TOP) begin
            return Q_HI_INT;
        end
        if (v < Q_BOTTOM) begin
            return Q_LO_INT;
        end
        return int'(v);
    endfunction

    function automatic int map_axis(input logic [jetp_pkg::PIX_W-1:0] pix, input int lo,
                                    input int hi, input logic [jetp_pkg::SIZE_W-1:0] size);
        longint span;
        longint divisor;
        span    = longint'(hi) - longint'(lo);
        divisor = (size == 0) ? 64'sd1 : longint'(size);
        return clamp_q(longint'(lo) + (longint'(pix) * span) / divisor);
    endfunction

    function automatic logic [jetp_pkg::CNT_OUT_W-1:0] predict_escape(
        input logic [jetp_pkg::PIX_W-1:0] px,
        input logic [jetp_pkg::PIX_W-1:0] py);
        longint          re;
        longint          im;
        longint          rr;
        longint          ii;
        longint          nre;
        longint          nim;
        longint unsigned mag;
        int              iters;
        re    = map_axis(px, win_re_lo, win_re_hi, img_w);
        im    = map_axis(py, win_im_lo, win_im_hi, img_h);
        iters = 0;
        while (iters < jetp_pkg::MAX_ITERATIONS) begin
            rr  = re * re;
            ii  = im * im;
            mag = rr + ii;
            if (mag > ESCAPE_SQ) begin
                break;
            end
            nre   = ((rr - ii) >>> FRAC) + c_re;
            nim   = ((re * im) >>> (FRAC - 1)) + c_im;
            re    = clamp_q(nre);
            im    = clamp_q(nim);
            iters = iters + 1;
        end
        return iters[jetp_pkg::CNT_OUT_W-1:0];
    endfunction

    function automatic logic [jetp_pkg::PIX_W-1:0] random_coord(
        input logic [jetp_pkg::SIZE_W-1:0] size);
        int lim;
        lim = (size > 13'd4096) ? 4096 : int'(size);
        if (size != 0 && $urandom_range(9) < 8) begin
            return jetp_pkg::PIX_W'($urandom_range(0, lim - 1));
        end
        return jetp_pkg::PIX_W'($urandom);
    endfunction

    always @(posedge i_clk) begin : check_results
        t_pixel_word want;
        if (i_rst_n && o_valid) begin
            if (pending_pixels.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected word: x=%0d y=%0d count=%0d",
                             o_out_x, o_out_y, o_escape_count);
                end
            end else begin
                want = pending_pixels.pop_front();
                words_checked++;
                if (want.count == jetp_pkg::CNT_OUT_W'(jetp_pkg::MAX_ITERATIONS)) begin
                    limit_hits++;
                end
                if (o_out_x !== want.x || o_out_y !== want.y ||
                    o_escape_count !== want.count) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected x=%0d y=%0d count=%0d, %s",
                                 want.x, want.y, want.count,
                                 $sformatf("got x=%0d y=%0d count=%0d",
                                           o_out_x, o_out_y, o_escape_count));
                    end
                end
            end
        end
    end

    task automatic write_reg(input jetp_pkg::t_cfg_idx idx,
                             input logic [jetp_pkg::Q_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
    endtask

    // block must be idle here
    task automatic apply_window(input int re_lo, input int re_hi, input int im_lo,
                                input int im_hi, input int k_re, input int k_im,
                                input logic [jetp_pkg::SIZE_W-1:0] w,
                                input logic [jetp_pkg::SIZE_W-1:0] h);
        write_reg(jetp_pkg::CFG_REAL_MIN, re_lo);
        write_reg(jetp_pkg::CFG_REAL_MAX, re_hi);
        write_reg(jetp_pkg::CFG_IMAG_MIN, im_lo);
        write_reg(jetp_pkg::CFG_IMAG_MAX, im_hi);
        write_reg(jetp_pkg::CFG_CONST_RE, k_re);
        write_reg(jetp_pkg::CFG_CONST_IM, k_im);
        write_reg(jetp_pkg::CFG_WIDTH, jetp_pkg::Q_W'(w));
        write_reg(jetp_pkg::CFG_HEIGHT, jetp_pkg::Q_W'(h));
        i_cfg_we  <= 1'b0;
        win_re_lo = re_lo;
        win_re_hi = re_hi;
        win_im_lo = im_lo;
        win_im_hi = im_hi;
        c_re      = k_re;
        c_im      = k_im;
        img_w     = w;
        img_h     = h;
        settings_applied++;
    endtask

    task automatic send_pixel(input logic [jetp_pkg::PIX_W-1:0] x,
                              input logic [jetp_pkg::PIX_W-1:0] y);
        int gap;
        gap = 0;
        if ($urandom_range(99) < idle_pct) begin
            gap = ($urandom_range(9) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 6);
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start     <= 1'b1;
        i_pixel_x <= x;
        i_pixel_y <= y;
        do @(posedge i_clk); while (busy);
        pending_pixels.push_back('{x: x, y: y, count: predict_escape(x, y)});
        words_sent++;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic test_reset_window();
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd512, 12'd512);
        send_pixel(12'd1023, 12'd0);
        send_pixel(12'd0, 12'd1023);
        send_pixel(12'd4095, 12'd0);
        drain_results();
    endtask

    task automatic test_window_extremes();
        apply_window(Q_LO_INT, Q_HI_INT, Q_LO_INT, Q_HI_INT, -214748365, 41875931, 13'd1, 13'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        drain_results();
    endtask

    task automatic test_zero_size();
        apply_window(-2 * Q_ONE, 2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE, 0, 0, 13'd0, 13'd0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd1);
        send_pixel(12'd4095, 12'd4095);
        drain_results();
    endtask

    task automatic test_reversed_window();
        apply_window(2 * Q_ONE, -2 * Q_ONE, 2 * Q_ONE, -2 * Q_ONE, Q_HI_INT, Q_LO_INT,
                     13'd4096, 13'd4096);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd2048, 12'd2048);
        send_pixel(12'd4095, 12'd4095);
        drain_results();
    endtask

    task automatic test_iterate_saturation();
        // z0 on the bailout circle, next iterate pushed past the q4.28 range
        apply_window(2 * Q_ONE, 2 * Q_ONE, 0, 0, 7 * Q_ONE, Q_LO_INT, 13'd4096, 13'd4096);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain_results();
    endtask

    task automatic test_bailout_boundary();
        apply_window(-2 * Q_ONE, 2 * Q_ONE, 0, 0, 0, 0, 13'd2, 13'd1);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd1, 12'd0);
        send_pixel(12'd2, 12'd0);
        drain_results();
    endtask

    task automatic test_random_pixels(input int style, input int n);
        int                          half;
        int                          ctr_re;
        int                          ctr_im;
        logic [jetp_pkg::PIX_W-1:0]  x;
        logic [jetp_pkg::PIX_W-1:0]  y;
        case (style)
            0: begin
                half   = $urandom_range(Q_ONE, 5 * Q_ONE / 2);
                ctr_re = int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4;
                ctr_im = int'($urandom_range(0, Q_ONE / 2)) - Q_ONE / 4;
                apply_window(ctr_re - half, ctr_re + half, ctr_im - half, ctr_im + half,
                             int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                             int'($urandom_range(0, 2 * Q_ONE)) - Q_ONE,
                             jetp_pkg::SIZE_W'($urandom_range(1, 4096)),
                             jetp_pkg::SIZE_W'($urandom_range(1, 4096)));
            end
            1: begin
                apply_window(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                             int'($urandom), int'($urandom),
                             jetp_pkg::SIZE_W'($urandom), jetp_pkg::SIZE_W'($urandom));
            end
            default: begin
                apply_window($urandom_range(1) ? Q_HI_INT : Q_LO_INT,
                             $urandom_range(1) ? Q_HI_INT : Q_LO_INT,
                             $urandom_range(1) ? Q_HI_INT : Q_LO_INT,
                             $urandom_range(1) ? Q_HI_INT : Q_LO_INT,
                             $urandom_range(1) ? Q_HI_INT : Q_LO_INT,
                             $urandom_range(1) ? Q_HI_INT : 0,
                             $urandom_range(1) ? 13'd1 : 13'd4096,
                             $urandom_range(1) ? 13'd1 : 13'd4096);
            end
        endcase
        for (int i = 0; i < n; i++) begin
            x = random_coord(img_w);
            y = random_coord(img_h);
            send_pixel(x, y);
            if (i == n / 2 && idle_pct > 50) begin
                drain_results();
            end
        end
        drain_results();
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        start      <= 1'b0;
        i_pixel_x  <= '0;
        i_pixel_y  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_addr <= jetp_pkg::CFG_REAL_MIN;
        i_cfg_data <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_window();
        test_window_extremes();
        test_zero_size();
        test_reversed_window();
        test_iterate_saturation();
        test_bailout_boundary();

        foreach (idle_pct_modes[m]) begin
            idle_pct = idle_pct_modes[m];
            test_random_pixels(0, PER_PHASE);
            test_random_pixels(1, PER_PHASE);
            test_random_pixels(0, PER_PHASE);
            test_random_pixels(2, PER_PHASE);
        end

        drain_results();
        repeat (200) @(posedge i_clk);
        $display("%0d pixels sent under %0d window settings, %0d results checked",
                 words_sent, settings_applied, words_checked);
        $display("%0d ran to the iteration limit, %0d escaped early, %0d mismatches, %0d missing",
                 limit_hits, words_checked - limit_hits, mismatches, pending_pixels.size());
        if (mismatches == 0 && pending_pixels.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #16_000_000;
        $display("timeout waiting for results");
        $display("== FAIL ==");
        $finish;
    end

endmodule
